// ===== rtl/ngar_pkg.sv =====
// Package for the nonzero group average rebinner.
// Holds widths, limits, the group record type and the back end state type.
package ngar_pkg;
  localparam int unsigned MaxGroup = 32;
  localparam int unsigned LenW = 6;
  localparam int unsigned SumW = 37;
  localparam int unsigned SqW = 64;
  localparam logic [LenW-1:0] LenReset = 6'd20;
  localparam logic [LenW-1:0] LenMin = 6'd2;
  localparam logic [LenW-1:0] LenMax = 6'd32;
  localparam int unsigned QDepth = 2;

  typedef struct packed {
    logic signed [SumW-1:0] value_sum;
    logic [SqW-1:0]         square_sum;
    logic [LenW-1:0]        count;
    logic                   saturated;
  } group_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_SQRT, ST_DIV_VAL, ST_DIV_ERR, ST_DONE
  } back_state_t;
endpackage

// ===== rtl/ngar_front.sv =====
// Front end: accumulates the nonzero bins of a group and pushes the finished group record.
// Depends on ngar_pkg.
module ngar_front (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic [ngar_pkg::LenW-1:0]    group_len,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic signed [31:0]           in_bin_value,
  input  logic [31:0]                  in_bin_error,
  output logic                         push,
  output ngar_pkg::group_t             push_group,
  input  logic                         q_full
);
  logic signed [ngar_pkg::SumW-1:0] sum_r, sum_nxt;
  logic [ngar_pkg::SqW-1:0] sq_r, sq_nxt;
  logic [ngar_pkg::LenW-1:0] cnt_r, cnt_nxt, pos_r, pos_nxt, eff_len;
  logic sat_r, sat_nxt, take, last;
  logic [63:0] sq_item;
  logic [64:0] sq_add;

  assign in_stall = q_full;
  assign take = in_valid && !q_full;

  always_comb begin
    if (group_len < ngar_pkg::LenMin) eff_len = ngar_pkg::LenMin;
    else if (group_len > ngar_pkg::LenMax) eff_len = ngar_pkg::LenMax;
    else eff_len = group_len;
  end

  assign sq_item = {32'd0, in_bin_error} * {32'd0, in_bin_error};
  assign sq_add = {1'b0, sq_r} + {1'b0, sq_item};

  always_comb begin
    sum_nxt = sum_r;
    sq_nxt = sq_r;
    cnt_nxt = cnt_r;
    sat_nxt = sat_r;
    if (in_bin_value != 32'sd0) begin
      sum_nxt = sum_r + {{(ngar_pkg::SumW-32){in_bin_value[31]}}, in_bin_value};
      cnt_nxt = cnt_r + 1'b1;
      if (sq_add[64] || (&sq_add[63:0])) begin
        sq_nxt = '1;
        sat_nxt = 1'b1;
      end else begin
        sq_nxt = sq_add[63:0];
      end
    end
    pos_nxt = pos_r + 1'b1;
    last = pos_nxt >= eff_len;
  end

  assign push = take && last;
  assign push_group = '{value_sum: sum_nxt, square_sum: sq_nxt, count: cnt_nxt,
                        saturated: sat_nxt};

  always_ff @(posedge clk) begin
    if (!rst_n || push) begin
      sum_r <= '0; sq_r <= '0; cnt_r <= '0; pos_r <= '0; sat_r <= 1'b0;
    end else if (take) begin
      sum_r <= sum_nxt; sq_r <= sq_nxt; cnt_r <= cnt_nxt; pos_r <= pos_nxt;
      sat_r <= sat_nxt;
    end
  end
endmodule

// ===== rtl/ngar_queue.sv =====
// Two entry queue of finished group records between front and back end.
// Depends on ngar_pkg.
module ngar_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  ngar_pkg::group_t push_group,
  output logic             full,
  input  logic             pop,
  output logic             not_empty,
  output ngar_pkg::group_t head
);
  ngar_pkg::group_t mem_r [ngar_pkg::QDepth];
  logic wp_r, rp_r;
  logic [1:0] fill_r;

  assign full = fill_r == 2'd2;
  assign not_empty = fill_r != 2'd0;
  assign head = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= push_group;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0; rp_r <= 1'b0; fill_r <= 2'd0;
    end else begin
      if (push) wp_r <= !wp_r;
      if (pop) rp_r <= !rp_r;
      fill_r <= fill_r + {1'b0, push} - {1'b0, pop};
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n) full |-> !push)
    else $error("push into full queue");
  assert property (@(posedge clk) disable iff (!rst_n) !not_empty |-> !pop)
    else $error("pop from empty queue");
  assert property (@(posedge clk) disable iff (!rst_n) fill_r <= 2'd2)
    else $error("queue fill out of range");
endmodule

// ===== rtl/ngar_back.sv =====
// Back end: square root and two divisions per nonempty group, one bit per cycle.
// Depends on ngar_pkg.
module ngar_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_not_empty,
  input  ngar_pkg::group_t    q_head,
  output logic                q_pop,
  output logic                out_valid,
  input  logic                out_stall,
  output logic signed [31:0]  out_mean_value,
  output logic [31:0]         out_mean_error,
  output logic                out_empty_group,
  output logic                out_squares_saturated
);
  ngar_pkg::back_state_t st_r, st_nxt;
  logic [63:0] rem_r, rem_nxt;
  logic [63:0] root_r, root_nxt;
  logic [63:0] bit_r, bit_nxt;
  logic [36:0] quo_r, quo_nxt, num_r, num_nxt;
  logic [36:0] drem_r, drem_nxt;
  logic [5:0] cnt_r, cnt_nxt, step_r, step_nxt;
  logic neg_r, neg_nxt, sat_r, sat_nxt, emp_r, emp_nxt;
  logic [31:0] mv_r, mv_nxt, me_r, me_nxt;
  logic [37:0] dtry;
  logic [36:0] absv;

  assign out_valid = st_r == ngar_pkg::ST_DONE;
  assign out_mean_value = mv_r;
  assign out_mean_error = me_r;
  assign out_empty_group = emp_r;
  assign out_squares_saturated = sat_r;
  assign absv = q_head.value_sum[36] ? 37'(-q_head.value_sum) : q_head.value_sum;
  assign dtry = {drem_r, num_r[36]} - {32'd0, cnt_r};

  always_comb begin
    st_nxt = st_r; rem_nxt = rem_r; root_nxt = root_r; bit_nxt = bit_r;
    quo_nxt = quo_r; num_nxt = num_r; drem_nxt = drem_r; cnt_nxt = cnt_r;
    step_nxt = step_r; neg_nxt = neg_r; sat_nxt = sat_r; emp_nxt = emp_r;
    mv_nxt = mv_r; me_nxt = me_r; q_pop = 1'b0;
    case (st_r)
      ngar_pkg::ST_IDLE: if (q_not_empty) begin
        q_pop = 1'b1;
        cnt_nxt = q_head.count;
        if (q_head.count == '0) begin
          mv_nxt = '0; me_nxt = '0; emp_nxt = 1'b1; sat_nxt = 1'b0;
          st_nxt = ngar_pkg::ST_DONE;
        end else begin
          emp_nxt = 1'b0; sat_nxt = q_head.saturated;
          rem_nxt = q_head.square_sum; root_nxt = '0;
          bit_nxt = 64'd1 << 62;
          neg_nxt = q_head.value_sum[36];
          num_nxt = absv; drem_nxt = '0; quo_nxt = '0; step_nxt = '0;
          st_nxt = ngar_pkg::ST_SQRT;
        end
      end
      ngar_pkg::ST_SQRT: begin
        if (rem_r >= root_r + bit_r) begin
          rem_nxt = rem_r - (root_r + bit_r);
          root_nxt = (root_r >> 1) + bit_r;
        end else begin
          root_nxt = root_r >> 1;
        end
        bit_nxt = bit_r >> 2;
        if (bit_r == 64'd1) st_nxt = ngar_pkg::ST_DIV_VAL;
      end
      ngar_pkg::ST_DIV_VAL, ngar_pkg::ST_DIV_ERR: begin
        num_nxt = num_r << 1;
        if (!dtry[37]) begin
          drem_nxt = dtry[36:0]; quo_nxt = {quo_r[35:0], 1'b1};
        end else begin
          drem_nxt = {drem_r[35:0], num_r[36]}; quo_nxt = {quo_r[35:0], 1'b0};
        end
        step_nxt = step_r + 1'b1;
        if (step_r == 6'd36) begin
          // The final quotient bit is in quo_nxt; take it before clearing.
          if (st_r == ngar_pkg::ST_DIV_VAL) begin
            mv_nxt = neg_r ? 32'(-quo_nxt) : quo_nxt[31:0];
            num_nxt = {5'd0, root_r[31:0]};
            st_nxt = ngar_pkg::ST_DIV_ERR;
          end else begin
            me_nxt = quo_nxt[31:0];
            st_nxt = ngar_pkg::ST_DONE;
          end
          step_nxt = '0; drem_nxt = '0; quo_nxt = '0;
        end
      end
      ngar_pkg::ST_DONE: if (!out_stall) st_nxt = ngar_pkg::ST_IDLE;
      default: st_nxt = ngar_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) st_r <= ngar_pkg::ST_IDLE;
    else st_r <= st_nxt;
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt; root_r <= root_nxt; bit_r <= bit_nxt; quo_r <= quo_nxt;
    num_r <= num_nxt; drem_r <= drem_nxt; cnt_r <= cnt_nxt; step_r <= step_nxt;
    neg_r <= neg_nxt; sat_r <= sat_nxt; emp_r <= emp_nxt; mv_r <= mv_nxt;
    me_r <= me_nxt;
  end

  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_empty_group |-> out_mean_value == '0 && out_mean_error == '0)
    else $error("empty group with nonzero result");
  assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> st_r == ngar_pkg::ST_IDLE)
    else $error("pop while busy");
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_empty_group |-> !out_squares_saturated)
    else $error("empty group flagged saturated");
endmodule

// ===== rtl/nonzero_group_average_rebinner_unit.sv =====
// Top level of the nonzero group average rebinner.
// A nonempty group is worked out in order: the pop from the queue, 32 root steps,
// then two 37 step divisions; an empty group goes from the pop straight to the result.
// Throughput: one bin per cycle while the two entry group queue has room; the
// serial back end takes a new group only once the last result has been taken.
// Reset is synchronous, active low; group length returns to 20, sums clear.
module nonzero_group_average_rebinner_unit (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [5:0]         cfg_wdata,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [31:0] in_bin_value,
  input  logic [31:0]        in_bin_error,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] out_mean_value,
  output logic [31:0]        out_mean_error,
  output logic               out_empty_group,
  output logic               out_squares_saturated
);
  // The group length register; out of range values are clamped in the front.
  logic [ngar_pkg::LenW-1:0] len_r;
  logic push, full, pop, not_empty;
  ngar_pkg::group_t push_group, head;

  always_ff @(posedge clk) begin
    if (!rst_n) len_r <= ngar_pkg::LenReset;
    else if (cfg_we) len_r <= cfg_wdata;
  end

  // The front accumulates bins and hands one record per group to the queue.
  ngar_front u_front (
    .clk, .rst_n, .group_len(len_r), .in_valid, .in_stall, .in_bin_value,
    .in_bin_error, .push, .push_group, .q_full(full)
  );

  ngar_queue u_queue (
    .clk, .rst_n, .push, .push_group, .full, .pop, .not_empty, .head
  );

  // The back end works out the root and quotients and holds the result word.
  ngar_back u_back (
    .clk, .rst_n, .q_not_empty(not_empty), .q_head(head), .q_pop(pop),
    .out_valid, .out_stall, .out_mean_value, .out_mean_error,
    .out_empty_group, .out_squares_saturated
  );
endmodule
